@@ hw/rtl/lr_pkg.sv @@
package lr_pkg;

  localparam int unsigned CoordW = 6;
  localparam int unsigned CharW  = 8;
  // error term spans -2*major .. 2*minor
  localparam int unsigned ErrW   = CoordW + 3;

  typedef struct packed {
    logic [CoordW-1:0] start_x;
    logic [CoordW-1:0] start_y;
    logic [CoordW-1:0] end_x;
    logic [CoordW-1:0] end_y;
    logic [CharW-1:0]  paint_char;
  } req_t;

  typedef struct packed {
    logic [CoordW-1:0] pixel_x;
    logic [CoordW-1:0] pixel_y;
    logic [CharW-1:0]  pixel_char;
    logic              last_pixel;
    logic              bad_request;
  } pix_t;

  typedef enum logic {
    StIdle,
    StRun
  } state_e;

  typedef struct packed {
    logic load;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } status_t;

endpackage

@@ hw/rtl/lr_ctrl.sv @@
module lr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  lr_pkg::status_t status_i,
  output lr_pkg::cmd_t    cmd_o
);

  lr_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lr_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    cmd_o      = '0;
    case (state_q)
      lr_pkg::StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = lr_pkg::StRun;
        end
      end
      lr_pkg::StRun: begin
        // advance one pixel whenever the output register can take it
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.last) begin
            state_d = lr_pkg::StIdle;
          end
        end
      end
      default: begin
        state_d = lr_pkg::StIdle;
      end
    endcase
  end

endmodule

@@ hw/rtl/lr_datapath.sv @@
module lr_datapath #(
  parameter int unsigned CANVAS_SIZE = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lr_pkg::req_t    req_i,
  input  lr_pkg::cmd_t    cmd_i,
  output lr_pkg::status_t status_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output lr_pkg::pix_t    out_data_o
);

  localparam int unsigned CW = lr_pkg::CoordW;
  localparam int unsigned EW = lr_pkg::ErrW;
  localparam logic [CW:0] Limit = (CW+1)'(CANVAS_SIZE);

  logic [CW:0]   dx, dy;
  logic          bad, xmaj;
  logic [CW-1:0] major, minor;
  logic [EW-1:0] inc_min, inc_both, err0;

  logic [CW-1:0]     x_q, y_q, cnt_q;
  logic [EW-1:0]     err_q, inc_min_q, inc_both_q;
  logic              xmaj_q, bad_q;
  logic [lr_pkg::CharW-1:0] char_q;
  logic              out_valid_q, out_valid_d;
  lr_pkg::pix_t      out_q, pix;
  logic              step_minor;

  always_comb begin
    dx   = {1'b0, req_i.end_x} - {1'b0, req_i.start_x};
    dy   = {1'b0, req_i.end_y} - {1'b0, req_i.start_y};
    bad  = dx[CW] || dy[CW] ||
           ({1'b0, req_i.start_x} >= Limit) || ({1'b0, req_i.start_y} >= Limit) ||
           ({1'b0, req_i.end_x} >= Limit) || ({1'b0, req_i.end_y} >= Limit);
    xmaj = dy[CW-1:0] < dx[CW-1:0];
    major = xmaj ? dx[CW-1:0] : dy[CW-1:0];
    minor = xmaj ? dy[CW-1:0] : dx[CW-1:0];
    inc_min  = {2'b00, minor, 1'b0};
    inc_both = inc_min - {2'b00, major, 1'b0};
    err0     = inc_min - {3'b000, major};
  end

  // minor axis steps when the error term is not negative
  assign step_minor = !err_q[EW-1];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q        <= req_i.start_x;
      y_q        <= req_i.start_y;
      cnt_q      <= major;
      err_q      <= err0;
      inc_min_q  <= inc_min;
      inc_both_q <= inc_both;
      xmaj_q     <= xmaj;
      bad_q      <= bad;
      char_q     <= req_i.paint_char;
    end else if (cmd_i.emit) begin
      cnt_q <= cnt_q - CW'(1);
      err_q <= err_q + (step_minor ? inc_both_q : inc_min_q);
      if (xmaj_q) begin
        x_q <= x_q + CW'(1);
        if (step_minor) y_q <= y_q + CW'(1);
      end else begin
        y_q <= y_q + CW'(1);
        if (step_minor) x_q <= x_q + CW'(1);
      end
    end
  end

  always_comb begin
    if (bad_q) begin
      pix             = '0;
      pix.last_pixel  = 1'b1;
      pix.bad_request = 1'b1;
    end else begin
      pix.pixel_x     = x_q;
      pix.pixel_y     = y_q;
      pix.pixel_char  = char_q;
      pix.last_pixel  = (cnt_q == '0);
      pix.bad_request = 1'b0;
    end
  end

  always_comb begin
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= pix;
    end
  end

  assign status_o.last     = bad_q || (cnt_q == '0);
  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

endmodule

@@ hw/rtl/line_rasterizer.sv @@
// The request is first loaded into the step unit's registers; each pixel is then registered
// into the output register. A line of n pixels is one load, then one pixel per cycle from the
// error-term step unit while the output does not stall; a refused request gives one bad_request item.
// Output stalls hold the step unit; the next request is taken while the last pixel waits.
// Reset (rst_ni low, asynchronous) returns the controller to idle and empties the output.
module line_rasterizer #(
  parameter int unsigned CANVAS_SIZE = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  lr_pkg::req_t in_data_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output lr_pkg::pix_t out_data_o
);

  lr_pkg::cmd_t    cmd;
  lr_pkg::status_t status;

  lr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lr_datapath #(
    .CANVAS_SIZE (CANVAS_SIZE)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ sim/tb_line_rasterizer.sv @@
`timescale 1ns / 1ps

module tb_line_rasterizer;

  localparam int CanvasSize = 64;
  localparam int RandLines  = 83;  // per phase
  localparam int unsigned CoordW = lr_pkg::CoordW;
  localparam int unsigned CharW  = lr_pkg::CharW;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  lr_pkg::req_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  lr_pkg::pix_t out_data_o;

  lr_pkg::req_t line_q[$];   // requests waiting to be driven
  lr_pkg::pix_t pixel_q[$];  // pixels expected from accepted requests
  bit   req_taken = 1'b0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   errors = 0;

  line_rasterizer #(.CANVAS_SIZE(CanvasSize)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Walk the line with the error term and queue every pixel it writes, or one bad_request item.
  task automatic plot_line(input lr_pkg::req_t r);
    int   x, y, dx, dy, err, steps;
    bit   xmaj;
    lr_pkg::pix_t p;
    x  = int'(r.start_x);
    y  = int'(r.start_y);
    dx = int'(r.end_x) - x;
    dy = int'(r.end_y) - y;
    if (dx < 0 || dy < 0 || x >= CanvasSize || y >= CanvasSize ||
        int'(r.end_x) >= CanvasSize || int'(r.end_y) >= CanvasSize) begin
      p = '0;
      p.last_pixel  = 1'b1;
      p.bad_request = 1'b1;
      pixel_q.push_back(p);
      return;
    end
    xmaj  = dy < dx;
    err   = xmaj ? 2 * dy - dx : 2 * dx - dy;
    steps = xmaj ? dx : dy;
    for (int i = 0; i <= steps; i++) begin
      p.pixel_x     = x[CoordW-1:0];
      p.pixel_y     = y[CoordW-1:0];
      p.pixel_char  = r.paint_char;
      p.last_pixel  = (i == steps);
      p.bad_request = 1'b0;
      pixel_q.push_back(p);
      if (xmaj) begin
        x++;
        if (err < 0) begin
          err += 2 * dy;
        end else begin
          err += 2 * dy - 2 * dx;
          y++;
        end
      end else begin
        y++;
        if (err < 0) begin
          err += 2 * dx;
        end else begin
          err += 2 * dx - 2 * dy;
          x++;
        end
      end
    end
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Sample both handshakes at the rising edge.
  always @(posedge clk_i) begin
    lr_pkg::pix_t want;
    req_taken <= in_valid_i && !in_stall_o;
    if (in_valid_i && !in_stall_o) begin
      plot_line(in_data_i);
    end
    if (out_valid_o && !out_stall_i) begin
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected pixel item: expected none, got %h", $time, out_data_o);
        errors++;
      end else begin
        want = pixel_q.pop_front();
        check_field("pixel_x", int'(want.pixel_x), int'(out_data_o.pixel_x));
        check_field("pixel_y", int'(want.pixel_y), int'(out_data_o.pixel_y));
        check_field("pixel_char", int'(want.pixel_char), int'(out_data_o.pixel_char));
        check_field("last_pixel", int'(want.last_pixel), int'(out_data_o.last_pixel));
        check_field("bad_request", int'(want.bad_request), int'(out_data_o.bad_request));
      end
    end
  end

  // Advance to the next request only after the current one was taken; hold otherwise.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || req_taken)) begin
      if (line_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i  <= line_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= rst_ni && ($urandom_range(99) < stall_pct);
  end

  task automatic add_line(input int sx, input int sy, input int ex, input int ey,
                          input int ch);
    lr_pkg::req_t r;
    r.start_x    = CoordW'(sx);
    r.start_y    = CoordW'(sy);
    r.end_x      = CoordW'(ex);
    r.end_y      = CoordW'(ey);
    r.paint_char = CharW'(ch);
    line_q.push_back(r);
  endtask

  // Mostly well-formed lines, many of them short; the rest raw noise.
  function automatic lr_pkg::req_t random_line();
    lr_pkg::req_t r;
    int   roll;
    int   sx, sy;
    roll = $urandom_range(99);
    r = lr_pkg::req_t'($urandom);
    if (roll >= 15) begin
      sx = int'(r.start_x);
      sy = int'(r.start_y);
      if (roll < 60) begin
        r.end_x = CoordW'(sx + $urandom_range((63 - sx < 8) ? 63 - sx : 8));
        r.end_y = CoordW'(sy + $urandom_range((63 - sy < 8) ? 63 - sy : 8));
      end else begin
        r.end_x = CoordW'($urandom_range(63, sx));
        r.end_y = CoordW'($urandom_range(63, sy));
      end
    end
    return r;
  endfunction

  task automatic drain();
    do begin
      @(posedge clk_i);
      #1;
    end while (line_q.size() != 0 || in_valid_i || pixel_q.size() != 0);
  endtask

  initial begin
    int phase_idle[4];
    int phase_stall[4];
    phase_idle  = '{0, 55, 0, 31};
    phase_stall = '{0, 0, 55, 31};
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    add_line(0, 0, 0, 0, 8'h00);      // single point at the origin
    add_line(63, 63, 63, 63, 8'hff);  // single point at the far corner
    add_line(0, 0, 63, 0, 8'h2a);     // full row
    add_line(0, 0, 0, 63, 8'h55);     // full column
    add_line(0, 0, 63, 63, 8'haa);    // full diagonal, y-major
    add_line(5, 9, 25, 29, 8'h23);    // equal deltas
    add_line(0, 0, 63, 1, 8'h01);     // shallow x-major
    add_line(0, 0, 1, 63, 8'h80);     // steep y-major
    add_line(10, 10, 21, 20, 8'h3c);  // dx one above dy
    add_line(10, 10, 20, 21, 8'hc3);  // dy one above dx
    add_line(3, 7, 40, 22, 8'h7f);
    add_line(12, 1, 19, 50, 8'hfe);
    add_line(20, 5, 19, 30, 8'h41);   // end column before start
    add_line(5, 20, 30, 19, 8'h42);   // end row before start
    add_line(63, 63, 0, 0, 8'hff);    // both before start
    add_line(63, 0, 0, 63, 8'h11);
    add_line(62, 62, 63, 63, 8'h99);
    add_line(0, 63, 63, 63, 8'h5a);
    add_line(63, 0, 63, 63, 8'ha5);
    add_line(1, 2, 4, 3, 8'h10);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = phase_idle[ph];
      stall_pct     = phase_stall[ph];
      for (int i = 0; i < RandLines; i++) begin
        line_q.push_back(random_line());
      end
      drain();
    end
    stall_pct = 0;
    repeat (10) @(posedge clk_i);
    if (errors == 0 && pixel_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
